FILE: sv/jsc_pkg.sv
`default_nettype none
package jsc_pkg;

  typedef enum logic [3:0] {
    TK_OBJ_OPEN  = 4'd0,
    TK_OBJ_CLOSE = 4'd1,
    TK_ARR_OPEN  = 4'd2,
    TK_ARR_CLOSE = 4'd3,
    TK_COLON     = 4'd4,
    TK_COMMA     = 4'd5,
    TK_STRING    = 4'd6,
    TK_NUMBER    = 4'd7,
    TK_BOOL      = 4'd8,
    TK_NULL      = 4'd9
  } tok_t;

  localparam logic [3:0] SCALAR_EV_OFFSET = 4'd3;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_OPEN_OBJ = 4'd1,
    EV_OPEN_ARR = 4'd2,
    EV_STRING   = 4'd3,
    EV_NUMBER   = 4'd4,
    EV_BOOL     = 4'd5,
    EV_NULL     = 4'd6,
    EV_CLOSE    = 4'd7,
    EV_DOC_OK   = 4'd8,
    EV_ERROR    = 4'd9
  } ev_t;

  typedef enum logic [3:0] {
    ER_NONE          = 4'd0,
    ER_AFTER_DOC     = 4'd1,
    ER_MISSING_COMMA = 4'd2,
    ER_COMMA_CLOSE   = 4'd3,
    ER_MISMATCH      = 4'd4,
    ER_MISSING_COLON = 4'd5,
    ER_NO_VALUE      = 4'd6,
    ER_MISSING_KEY   = 4'd7,
    ER_UNCLOSED      = 4'd8,
    ER_BAD_START     = 4'd9,
    ER_STRAY_COLON   = 4'd10,
    ER_TOO_DEEP      = 4'd11,
    ER_EMPTY         = 4'd12
  } err_t;

  typedef enum logic [1:0] {
    DOC_ROOT   = 2'd0,
    DOC_INSIDE = 2'd1,
    DOC_DONE   = 2'd2,
    DOC_ERROR  = 2'd3
  } doc_t;

  typedef enum logic [1:0] {
    MP_KEY   = 2'd0,
    MP_COLON = 2'd1,
    MP_VALUE = 2'd2
  } member_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_FAIL,
    A_VALUE,
    A_CLOSE,
    A_COMMA,
    A_KEY,
    A_COLON,
    A_EOD
  } act_t;

  typedef struct packed {
    logic       eod;
    logic       bad;
    logic       is_val;
    logic       is_open;
    logic [3:0] tok;
  } cls_t;

  typedef struct packed {
    ev_t         event_res;
    logic [15:0] value_index;
    logic [15:0] key_index;
    logic        has_key;
    logic [5:0]  depth;
    err_t        error_code;
  } res_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam logic [5:0] DEPTH_LIMIT_RESET = 6'd32;

endpackage
`default_nettype wire

FILE: sv/jsc_front.sv
`default_nettype none
module jsc_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tlast,
  output logic               q_valid,
  input  wire logic          q_ready,
  output jsc_pkg::cls_t      q_data
);
  import jsc_pkg::*;

  logic [3:0] tok;
  logic       bad;

  assign tok = s_tdata[3:0];
  assign bad = tok > TK_NULL;

  always_comb begin
    q_data.eod     = s_tlast;
    q_data.tok     = tok;
    q_data.bad     = bad;
    q_data.is_open = (tok == TK_OBJ_OPEN) || (tok == TK_ARR_OPEN);
    q_data.is_val  = q_data.is_open || ((tok >= TK_STRING) && !bad);
  end

  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;

endmodule
`default_nettype wire

FILE: sv/jsc_queue.sv
`default_nettype none
module jsc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jsc_pkg::cls_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jsc_pkg::cls_t      out_data
);
  import jsc_pkg::*;

  cls_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;

  assign in_ready  = count != (QAW+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/jsc_back.sv
`default_nettype none
module jsc_back #(
  parameter int MAX_DEPTH  = 32,
  parameter int INDEX_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jsc_pkg::cls_t in_data,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_wdata,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jsc_pkg::res_t      out_data
);
  import jsc_pkg::*;

  localparam int LVL_BITS = $clog2(MAX_DEPTH + 1);
  localparam int CW       = (LVL_BITS > 6) ? LVL_BITS : 6;

  logic [MAX_DEPTH-1:0]  nest;
  logic [MAX_DEPTH-1:0]  nest_next;
  logic [LVL_BITS-1:0]   stack_level;
  logic [LVL_BITS-1:0]   stack_level_next;
  doc_t                  doc_phase;
  doc_t                  doc_phase_next;
  member_t               member_phase;
  member_t               member_phase_next;
  logic                  comma_seen;
  logic                  comma_seen_next;
  logic                  comma_needed;
  logic                  comma_needed_next;
  logic [INDEX_BITS-1:0] value_counter;
  logic [INDEX_BITS-1:0] value_counter_next;
  logic [INDEX_BITS-1:0] pending_key;
  logic [INDEX_BITS-1:0] pending_key_next;
  err_t                  err_latch;
  err_t                  err_latch_next;
  logic [5:0]            depth_limit;

  act_t     act;
  err_t     fail_code;
  logic     keyed;
  logic     fire;
  logic     too_deep;
  logic [CW-1:0] lvl_w;
  logic [CW-1:0] lim_w;
  res_t     res;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign lvl_w    = CW'(stack_level);
  assign lim_w    = (CW'(depth_limit) < CW'(MAX_DEPTH)) ? CW'(depth_limit) : CW'(MAX_DEPTH);
  assign too_deep = lvl_w >= lim_w;

  always_comb begin
    act       = A_NONE;
    fail_code = ER_NONE;
    keyed     = 1'b0;
    priority if (in_data.eod) begin
      act = A_EOD;
    end else if (doc_phase == DOC_ERROR || in_data.bad) begin
      act = A_NONE;
    end else if (doc_phase == DOC_DONE) begin
      act       = A_FAIL;
      fail_code = ER_AFTER_DOC;
    end else if (doc_phase == DOC_ROOT || stack_level == '0) begin
      if (in_data.is_val) begin
        act = A_VALUE;
      end else begin
        act       = A_FAIL;
        fail_code = ER_BAD_START;
      end
    end else if (!nest[0]) begin
      priority if (in_data.is_val && comma_needed) begin
        act       = A_FAIL;
        fail_code = ER_MISSING_COMMA;
      end else if (in_data.is_val) begin
        act = A_VALUE;
      end else if (in_data.tok == TK_COMMA) begin
        act = A_COMMA;
      end else if (in_data.tok == TK_ARR_CLOSE) begin
        if (comma_seen) begin
          act       = A_FAIL;
          fail_code = ER_COMMA_CLOSE;
        end else begin
          act = A_CLOSE;
        end
      end else if (in_data.tok == TK_OBJ_CLOSE) begin
        act       = A_FAIL;
        fail_code = ER_MISMATCH;
      end else begin
        act       = A_FAIL;
        fail_code = ER_STRAY_COLON;
      end
    end else if (member_phase == MP_COLON) begin
      if (in_data.tok == TK_COLON) begin
        act = A_COLON;
      end else begin
        act       = A_FAIL;
        fail_code = ER_MISSING_COLON;
      end
    end else if (member_phase == MP_VALUE) begin
      if (in_data.is_val) begin
        act   = A_VALUE;
        keyed = 1'b1;
      end else begin
        act       = A_FAIL;
        fail_code = ER_NO_VALUE;
      end
    end else begin
      priority if (in_data.tok == TK_STRING) begin
        if (comma_needed) begin
          act       = A_FAIL;
          fail_code = ER_MISSING_COMMA;
        end else begin
          act = A_KEY;
        end
      end else if (in_data.tok == TK_COMMA) begin
        act = A_COMMA;
      end else if (in_data.tok == TK_OBJ_CLOSE) begin
        if (comma_seen) begin
          act       = A_FAIL;
          fail_code = ER_COMMA_CLOSE;
        end else begin
          act = A_CLOSE;
        end
      end else if (in_data.tok == TK_ARR_CLOSE) begin
        act       = A_FAIL;
        fail_code = ER_MISMATCH;
      end else begin
        act       = A_FAIL;
        fail_code = ER_MISSING_KEY;
      end
    end
  end

  always_comb begin
    nest_next          = nest;
    stack_level_next   = stack_level;
    doc_phase_next     = doc_phase;
    member_phase_next  = member_phase;
    comma_seen_next    = comma_seen;
    comma_needed_next  = comma_needed;
    value_counter_next = value_counter;
    pending_key_next   = pending_key;
    err_latch_next     = err_latch;
    res.event_res      = EV_NONE;
    res.value_index    = '0;
    res.key_index      = '0;
    res.has_key        = 1'b0;
    res.error_code     = ER_NONE;

    if (act == A_VALUE && in_data.is_open && too_deep) begin
      doc_phase_next = DOC_ERROR;
      err_latch_next = ER_TOO_DEEP;
      res.event_res  = EV_ERROR;
      res.error_code = ER_TOO_DEEP;
    end else begin
      unique case (act)
        A_NONE: begin
        end
        A_FAIL: begin
          doc_phase_next = DOC_ERROR;
          err_latch_next = fail_code;
          res.event_res  = EV_ERROR;
          res.error_code = fail_code;
        end
        A_VALUE: begin
          res.key_index = keyed ? 16'(pending_key) : '0;
          res.has_key   = keyed;
          member_phase_next = MP_KEY;
          comma_seen_next   = 1'b0;
          if (in_data.is_open) begin
            nest_next         = MAX_DEPTH'({nest, in_data.tok == TK_OBJ_OPEN});
            stack_level_next  = stack_level + 1'b1;
            doc_phase_next    = DOC_INSIDE;
            comma_needed_next = 1'b0;
            res.event_res     = (in_data.tok == TK_OBJ_OPEN) ? EV_OPEN_OBJ : EV_OPEN_ARR;
          end else begin
            value_counter_next = value_counter + 1'b1;
            comma_needed_next  = 1'b1;
            res.value_index    = 16'(value_counter);
            res.event_res      = ev_t'(in_data.tok - SCALAR_EV_OFFSET);
            if (doc_phase == DOC_ROOT || stack_level == '0) begin
              doc_phase_next = DOC_DONE;
            end
          end
        end
        A_CLOSE: begin
          nest_next         = nest >> 1;
          stack_level_next  = stack_level - 1'b1;
          comma_seen_next   = 1'b0;
          member_phase_next = MP_KEY;
          if (stack_level == LVL_BITS'(1)) begin
            doc_phase_next    = DOC_DONE;
            comma_needed_next = 1'b0;
          end else begin
            comma_needed_next = 1'b1;
          end
          res.event_res = EV_CLOSE;
        end
        A_COMMA: begin
          comma_seen_next   = 1'b1;
          comma_needed_next = 1'b0;
        end
        A_KEY: begin
          pending_key_next   = value_counter;
          value_counter_next = value_counter + 1'b1;
          comma_seen_next    = 1'b0;
          member_phase_next  = MP_COLON;
        end
        A_COLON: begin
          member_phase_next = MP_VALUE;
        end
        A_EOD: begin
          stack_level_next   = '0;
          doc_phase_next     = DOC_ROOT;
          member_phase_next  = MP_KEY;
          comma_seen_next    = 1'b0;
          comma_needed_next  = 1'b0;
          value_counter_next = '0;
          pending_key_next   = '0;
          err_latch_next     = ER_NONE;
          unique case (doc_phase)
            DOC_DONE: begin
              res.event_res = EV_DOC_OK;
            end
            DOC_ERROR: begin
              res.event_res  = EV_ERROR;
              res.error_code = err_latch;
            end
            DOC_ROOT: begin
              res.event_res  = EV_ERROR;
              res.error_code = ER_EMPTY;
            end
            default: begin
              res.event_res  = EV_ERROR;
              res.error_code = ER_UNCLOSED;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.depth = 6'(stack_level_next);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      nest     <= nest_next;
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_level   <= '0;
      doc_phase     <= DOC_ROOT;
      member_phase  <= MP_KEY;
      comma_seen    <= 1'b0;
      comma_needed  <= 1'b0;
      value_counter <= '0;
      pending_key   <= '0;
      err_latch     <= ER_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        stack_level   <= stack_level_next;
        doc_phase     <= doc_phase_next;
        member_phase  <= member_phase_next;
        comma_seen    <= comma_seen_next;
        comma_needed  <= comma_needed_next;
        value_counter <= value_counter_next;
        pending_key   <= pending_key_next;
        err_latch     <= err_latch_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RESET;
    end else if (cfg_we) begin
      depth_limit <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

FILE: sv/json_structure_checker.sv
`default_nettype none
// Structural checker for a JSON token stream. Each input word carries one
// token code (or, with tlast set, the end of a document) and yields exactly one
// output word: a tree event, a scalar with its value index and member-name
// index, or a numbered error that latches until the end of the document. The
// block takes one word per clock and gives one per clock while the output is
// not stalled; the front classifies tokens into a four-entry queue, and the
// back updates the nesting shift register and flags and registers the result.
// Nesting depth is bounded by the lesser of depth_limit and MAX_DEPTH; write
// depth_limit only while idle.
module json_structure_checker #(
  parameter int MAX_DEPTH  = 32,
  parameter int INDEX_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // token_code[3:0], zero pad
  input  wire logic        s_tlast,   // end of document
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // value_index, key_index, has_key, depth, error_code, pad
  output logic [3:0]       m_tuser,   // event_res
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);
  import jsc_pkg::*;

  logic  fq_valid;
  logic  fq_ready;
  cls_t  fq_data;
  logic  qb_valid;
  logic  qb_ready;
  cls_t  qb_data;
  res_t  res;

  jsc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  jsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  jsc_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_data   (qb_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tuser = res.event_res;
  assign m_tdata = {5'd0, res.error_code, res.depth, res.has_key,
                    res.key_index, res.value_index};

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
  import jsc_pkg::*;

  localparam int MAXD       = 32;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic       eod;
    logic [3:0] tok;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [47:0] m_tdata;
  wire logic [3:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = 6'd0;

  json_structure_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_t      pend[$];
  res_t       events_due[$];
  logic [3:0] draft[$];
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  // shadow of the checker state
  doc_t        doc_ph = DOC_ROOT;
  member_t     member_ph = MP_KEY;
  logic [31:0] nest_bits = '0;
  logic [5:0]  level = '0;
  logic        comma_seen_f = 1'b0;
  logic        comma_need_f = 1'b0;
  logic [15:0] next_value = '0;
  logic [15:0] key_held = '0;
  err_t        err_held = ER_NONE;
  logic [5:0]  depth_cap = DEPTH_LIMIT_RESET;

  function automatic void rearm_doc();
    level = '0;
    doc_ph = DOC_ROOT;
    member_ph = MP_KEY;
    comma_seen_f = 1'b0;
    comma_need_f = 1'b0;
    next_value = '0;
    key_held = '0;
    err_held = ER_NONE;
  endfunction

  function automatic res_t flag_error(input err_t code);
    res_t r;
    r = '0;
    doc_ph = DOC_ERROR;
    err_held = code;
    r.event_res = EV_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t comma_word();
    res_t r;
    r = '0;
    comma_seen_f = 1'b1;
    comma_need_f = 1'b0;
    return r;
  endfunction

  function automatic res_t close_level();
    res_t r;
    r = '0;
    level = level - 6'd1;
    comma_seen_f = 1'b0;
    member_ph = MP_KEY;
    if (level == 0) begin
      doc_ph = DOC_DONE;
      comma_need_f = 1'b0;
    end else begin
      comma_need_f = 1'b1;
    end
    r.event_res = EV_CLOSE;
    return r;
  endfunction

  function automatic res_t take_value(input logic [3:0] tok, input logic keyed);
    res_t r;
    int   lim;
    r = '0;
    if (tok == TK_OBJ_OPEN || tok == TK_ARR_OPEN) begin
      lim = (depth_cap < MAXD) ? depth_cap : MAXD;
      if (level >= lim) return flag_error(ER_TOO_DEEP);
      nest_bits[level] = (tok == TK_OBJ_OPEN);
      level = level + 6'd1;
      doc_ph = DOC_INSIDE;
      member_ph = MP_KEY;
      comma_seen_f = 1'b0;
      comma_need_f = 1'b0;
      r.event_res = (tok == TK_OBJ_OPEN) ? EV_OPEN_OBJ : EV_OPEN_ARR;
    end else begin
      r.value_index = next_value;
      next_value = next_value + 16'd1;
      comma_need_f = 1'b1;
      comma_seen_f = 1'b0;
      member_ph = MP_KEY;
      r.event_res = ev_t'(tok - SCALAR_EV_OFFSET);
    end
    r.key_index = keyed ? key_held : 16'd0;
    r.has_key = keyed;
    return r;
  endfunction

  function automatic res_t track_word(input logic eod, input logic [3:0] tok);
    res_t  r;
    doc_t  ph;
    err_t  code;
    logic  is_val;
    r = '0;
    is_val = (tok == TK_OBJ_OPEN || tok == TK_ARR_OPEN || tok >= TK_STRING);
    if (eod) begin
      ph = doc_ph;
      code = err_held;
      rearm_doc();
      if (ph == DOC_DONE) begin
        r.event_res = EV_DOC_OK;
      end else begin
        r.event_res = EV_ERROR;
        r.error_code = (ph == DOC_ERROR) ? code : (ph == DOC_ROOT) ? ER_EMPTY : ER_UNCLOSED;
      end
    end else if (doc_ph == DOC_ERROR || tok > TK_NULL) begin
      r = '0;
    end else if (doc_ph == DOC_DONE) begin
      r = flag_error(ER_AFTER_DOC);
    end else if (doc_ph == DOC_ROOT || level == 0) begin
      if (is_val) begin
        r = take_value(tok, 1'b0);
        if (tok >= TK_STRING) doc_ph = DOC_DONE;
      end else begin
        r = flag_error(ER_BAD_START);
      end
    end else if (!nest_bits[level - 6'd1]) begin
      if (is_val && comma_need_f) r = flag_error(ER_MISSING_COMMA);
      else if (is_val) r = take_value(tok, 1'b0);
      else if (tok == TK_COMMA) r = comma_word();
      else if (tok == TK_ARR_CLOSE) r = comma_seen_f ? flag_error(ER_COMMA_CLOSE) : close_level();
      else if (tok == TK_OBJ_CLOSE) r = flag_error(ER_MISMATCH);
      else r = flag_error(ER_STRAY_COLON);
    end else if (member_ph == MP_COLON) begin
      if (tok == TK_COLON) member_ph = MP_VALUE;
      else r = flag_error(ER_MISSING_COLON);
    end else if (member_ph == MP_VALUE) begin
      r = is_val ? take_value(tok, 1'b1) : flag_error(ER_NO_VALUE);
    end else if (tok == TK_STRING) begin
      if (comma_need_f) begin
        r = flag_error(ER_MISSING_COMMA);
      end else begin
        key_held = next_value;
        next_value = next_value + 16'd1;
        comma_seen_f = 1'b0;
        member_ph = MP_COLON;
      end
    end else if (tok == TK_COMMA) begin
      r = comma_word();
    end else if (tok == TK_OBJ_CLOSE) begin
      r = comma_seen_f ? flag_error(ER_COMMA_CLOSE) : close_level();
    end else if (tok == TK_ARR_CLOSE) begin
      r = flag_error(ER_MISMATCH);
    end else begin
      r = flag_error(ER_MISSING_KEY);
    end
    r.depth = level;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) events_due = {events_due, track_word(s_tlast, s_tdata[3:0])};
      if (pend.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        w = pend.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, w.tok};
        s_tlast <= w.eod;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.event_res = ev_t'(m_tuser);
      got.value_index = m_tdata[15:0];
      got.key_index = m_tdata[31:16];
      got.has_key = m_tdata[32];
      got.depth = m_tdata[38:33];
      got.error_code = err_t'(m_tdata[42:39]);
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: ev=%0d vi=%0d ki=%0d hk=%0d d=%0d err=%0d",
                   got.event_res, got.value_index, got.key_index, got.has_key,
                   got.depth, got.error_code);
      end else begin
        want = events_due.pop_front();
        if (got.event_res !== want.event_res || got.value_index !== want.value_index ||
            got.key_index !== want.key_index || got.has_key !== want.has_key ||
            got.depth !== want.depth || got.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ev=%0d vi=%0d ki=%0d hk=%0d d=%0d err=%0d",
                      " / got ev=%0d vi=%0d ki=%0d hk=%0d d=%0d err=%0d"},
                     want.event_res, want.value_index, want.key_index, want.has_key,
                     want.depth, want.error_code, got.event_res, got.value_index,
                     got.key_index, got.has_key, got.depth, got.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic put(input logic eod, input logic [3:0] tok);
    word_t w;
    w.eod = eod;
    w.tok = tok;
    pend = {pend, w};
  endtask

  function automatic void append_tok(input logic [3:0] tok);
    draft = {draft, tok};
  endfunction

  task automatic gen_value(input int lvl, input int maxd, input bit dive);
    int r;
    int n;
    bit obj;
    r = $urandom_range(9);
    if (lvl >= maxd || (!dive && r < 5)) begin
      append_tok(4'($urandom_range(TK_STRING, TK_NULL)));
    end else begin
      obj = dive ? $urandom_range(1) : (r < 7);
      n = dive ? 1 : $urandom_range(lvl < 2 ? 3 : 1);
      append_tok(obj ? TK_OBJ_OPEN : TK_ARR_OPEN);
      for (int i = 0; i < n; i++) begin
        if (i > 0) append_tok(TK_COMMA);
        if (obj) begin
          append_tok(TK_STRING);
          append_tok(TK_COLON);
        end
        gen_value(lvl + 1, maxd, dive);
      end
      append_tok(obj ? TK_OBJ_CLOSE : TK_ARR_CLOSE);
    end
  endtask

  task automatic drain();
    while (pend.size() != 0 || s_tvalid || events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int limits[8];
    int r;
    int idx;
    limits = '{32, 1, 7, 32, 2, 0, 31, 32};
    limits[5] = $urandom_range(1, 32);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(0, TK_NUMBER); put(1, TK_NUMBER);
    put(1, TK_NULL);
    put(0, TK_OBJ_OPEN); put(0, TK_STRING); put(0, TK_COLON); put(0, TK_ARR_OPEN);
    put(0, TK_ARR_CLOSE); put(0, TK_STRING); put(1, TK_OBJ_OPEN);
    put(0, TK_ARR_OPEN); put(0, TK_COLON); put(1, TK_COLON);
    put(0, TK_ARR_OPEN); put(0, TK_COMMA); put(0, TK_NULL); put(0, TK_COMMA);
    put(0, TK_ARR_CLOSE); put(1, TK_COMMA);
    put(0, TK_OBJ_OPEN); put(0, TK_COLON); put(0, 4'd15); put(1, TK_BOOL);
    put(0, TK_NUMBER); put(0, TK_BOOL); put(1, TK_STRING);
    drain();

    for (int p = 0; p < 8; p++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= 6'(limits[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      depth_cap = 6'(limits[p]);
      case (p % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 45; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 45; end
        default: begin src_idle_pct = 19; snk_stall_pct = 19; end
      endcase
      while (pend.size() < 206) begin
        draft.delete();
        r = $urandom_range(99);
        if (r < 8) begin
          repeat ($urandom_range(1, 8)) append_tok(4'($urandom_range(15)));
        end else begin
          if (r < 16) gen_value(0, $urandom_range(1, MAXD + 1), 1'b1);
          else gen_value(0, $urandom_range(1, 4), 1'b0);
          if ($urandom_range(99) < 25) begin
            idx = $urandom_range(draft.size() - 1);
            case ($urandom_range(2))
              0: draft[idx] = 4'($urandom_range(15));
              1: draft.delete(idx);
              default: draft.insert(idx, 4'($urandom_range(15)));
            endcase
          end
        end
        foreach (draft[i]) put(1'b0, draft[i]);
        put(1'b1, 4'($urandom_range(15)));
      end
      drain();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/jsc_pkg.sv
sv/jsc_front.sv
sv/jsc_queue.sv
sv/jsc_back.sv
sv/json_structure_checker.sv
tb/testbench.sv
